// ===== hw/rtl/lept_pkg.sv =====
// ----------------------------------------------------------------------------
// lept_pkg
// Shared types and codes for the leader election core and its peer table.
// ----------------------------------------------------------------------------
`default_nettype none

package lept_pkg;

  // default sizes
  localparam int DEF_PEER_SLOTS = 16;
  localparam int DEF_TERM_BITS  = 16;

  // message bytes
  localparam logic [7:0] BCAST_BYTE = 8'h46;  // 'F'
  localparam logic [7:0] KIND_HB    = 8'h48;  // 'H'
  localparam logic [7:0] KIND_VOTE  = 8'h56;  // 'V'
  localparam logic [7:0] KIND_ELECT = 8'h45;  // 'E'
  localparam logic [7:0] KIND_ACK   = 8'h41;  // 'A'

  // vote counter ceiling
  localparam logic [4:0] VOTE_MAX = 5'd31;

  // role codes
  localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
  localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
  localparam logic [1:0] ROLE_LEADER    = 2'd2;

  // command codes
  localparam logic CMD_MESSAGE = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  // configuration register indexes and reset values
  localparam logic [7:0] REG_MY_ID       = 8'd0;
  localparam logic [7:0] REG_STALE_LIMIT = 8'd1;
  localparam logic [7:0] MY_ID_RESET     = 8'd48;
  localparam logic [7:0] STALE_RESET     = 8'd5;

  // input transaction
  typedef struct packed {
    logic       command;
    logic [7:0] src_id;
    logic [7:0] dst_id;
    logic [7:0] msg_kind;
  } in_item_t;

  // output transaction
  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_dest;
    logic [7:0] send_kind;
    logic       restart_timer;
    logic [1:0] role;
    logic [4:0] known_devices;
    logic       last;
  } out_item_t;

  // peer table request
  typedef struct packed {
    logic       start;
    logic       touch;
    logic [7:0] src_id;
    logic [7:0] stale_limit;
  } tbl_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/leader_election_with_peer_table_core.sv =====
// ----------------------------------------------------------------------------
// leader_election_with_peer_table_core
// Leader election node: role, votes, term and a table of known peers.
// ----------------------------------------------------------------------------
// Each input transaction (received message or election timeout) is handled
// one at a time and gives one result, or two when the node is promoted to
// leader. An item holds off the next one until the table has walked every
// peer slot through the single read port of the table memory, one slot per
// cycle, followed by a write of the touch for a message (a timeout skips the
// write), and until its result, and a second one for a promotion, has been
// loaded into the output register; a stalled output delays this further.
// A finished result waits in the output register while the next item is
// taken. Configuration writes are always ready and are meant for idle times.
`default_nettype none

module leader_election_with_peer_table_core #(
  parameter int PEER_SLOTS = lept_pkg::DEF_PEER_SLOTS,
  parameter int TERM_BITS  = lept_pkg::DEF_TERM_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lept_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lept_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [7:0]          cfg_index,
  input  wire logic [7:0]          cfg_data
);

  import lept_pkg::*;

  localparam int DEV_W = $clog2(PEER_SLOTS + 2);
  localparam int CMP_W = (DEV_W > 5) ? DEV_W : 5;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_WAIT  = 5'b00100,
    S_ACT   = 5'b01000,
    S_PROMO = 5'b10000
  } state_t;

  state_t               state;
  in_item_t             item;
  logic [7:0]           my_id;
  logic [7:0]           stale_limit;
  logic [1:0]           node_role;
  logic [4:0]           vote_count;
  logic [TERM_BITS-1:0] term_counter;

  tbl_req_t             tbl_req;
  logic                 tbl_done;
  logic [DEV_W-1:0]     dev_total;

  logic                 out_free;
  logic                 out_load;
  logic                 addr_ok;
  logic [1:0]           role_act;
  logic [4:0]           vote_act;
  logic [TERM_BITS-1:0] term_act;
  logic                 sv;
  logic [7:0]           sdst;
  logic [7:0]           skind;
  logic                 rt;
  logic                 promote;
  out_item_t            res1;
  out_item_t            res2;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state inside {S_ACT, S_PROMO}) && out_free;

  // peer table
  assign tbl_req = '{start:       (state == S_START),
                     touch:       (item.command == CMD_MESSAGE),
                     src_id:      item.src_id,
                     stale_limit: stale_limit};

  lept_table #(
    .PEER_SLOTS (PEER_SLOTS),
    .TERM_BITS  (TERM_BITS)
  ) u_table (
    .clk          (clk),
    .rst          (rst),
    .req          (tbl_req),
    .term         (term_counter),
    .done         (tbl_done),
    .device_total (dev_total)
  );

  // event action once the table pass is done
  always_comb begin
    role_act = node_role;
    vote_act = vote_count;
    term_act = term_counter;
    sv       = 1'b0;
    sdst     = 8'd0;
    skind    = 8'd0;
    rt       = 1'b0;
    addr_ok  = (item.dst_id == BCAST_BYTE) || (item.dst_id == my_id);
    if (item.command == CMD_TIMEOUT) begin
      case (node_role)
        ROLE_LEADER: begin
          vote_act = 5'd0;
          sv       = 1'b1;
          sdst     = BCAST_BYTE;
          skind    = KIND_HB;
        end
        ROLE_FOLLOWER: begin
          role_act = ROLE_CANDIDATE;
          vote_act = 5'd1;
          sv       = 1'b1;
          sdst     = BCAST_BYTE;
          skind    = KIND_ELECT;
        end
        default: begin
          role_act = ROLE_FOLLOWER;
          vote_act = 5'd0;
        end
      endcase
    end else if (addr_ok) begin
      case (item.msg_kind)
        KIND_HB: begin
          rt       = 1'b1;
          role_act = ROLE_FOLLOWER;
          vote_act = 5'd0;
          sv       = 1'b1;
          sdst     = BCAST_BYTE;
          skind    = KIND_ACK;
          term_act = term_counter + 1'b1;
        end
        KIND_VOTE: begin
          if ((node_role == ROLE_CANDIDATE) && (vote_count < VOTE_MAX)) begin
            vote_act = vote_count + 1'b1;
          end
        end
        KIND_ELECT: begin
          if (node_role == ROLE_FOLLOWER) begin
            sv    = 1'b1;
            sdst  = item.src_id;
            skind = KIND_VOTE;
          end else if (node_role == ROLE_LEADER) begin
            sv    = 1'b1;
            sdst  = item.src_id;
            skind = KIND_HB;
          end
        end
        default: begin
        end
      endcase
    end
    // majority check
    promote = (CMP_W'(dev_total) >> 1) < CMP_W'(vote_act);
    res1 = '{send_valid:    sv,
             send_dest:     sdst,
             send_kind:     skind,
             restart_timer: rt,
             role:          role_act,
             known_devices: 5'(dev_total),
             last:          !promote};
    res2 = '{send_valid:    1'b1,
             send_dest:     BCAST_BYTE,
             send_kind:     KIND_HB,
             restart_timer: 1'b0,
             role:          ROLE_LEADER,
             known_devices: 5'(dev_total),
             last:          1'b1};
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      my_id       <= MY_ID_RESET;
      stale_limit <= STALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MY_ID:       my_id       <= cfg_data;
        REG_STALE_LIMIT: stale_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer, node state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      node_role    <= ROLE_FOLLOWER;
      vote_count   <= 5'd0;
      term_counter <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            item  <= in_data;
            state <= S_START;
            // a timeout ages the table against the advanced term
            if (in_data.command == CMD_TIMEOUT) begin
              term_counter <= term_counter + 1'b1;
            end
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (tbl_done) begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          if (out_free) begin
            out_data     <= res1;
            term_counter <= term_act;
            node_role    <= promote ? ROLE_LEADER : role_act;
            vote_count   <= promote ? 5'd0 : vote_act;
            state        <= promote ? S_PROMO : S_IDLE;
          end
        end
        S_PROMO: begin
          if (out_free) begin
            out_data  <= res2;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    tbl_done |-> (state == S_WAIT))
    else $error("peer table finished outside of wait");

  a_dev_nonzero: assert property (@(posedge clk) disable iff (rst)
    dev_total != '0)
    else $error("device count dropped to zero");

  a_first_not_leader: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last) |-> (out_data.role != ROLE_LEADER))
    else $error("first result of a promotion already shows leader");

  a_promo_state: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROMO) |-> ((node_role == ROLE_LEADER) && (vote_count == 5'd0)))
    else $error("promotion pending without leader role and cleared votes");

endmodule

`default_nettype wire

// ===== hw/rtl/lept_table.sv =====
// ----------------------------------------------------------------------------
// lept_table
// Peer table: one pass over all slots refreshes or finds room for the sender
// and drops peers whose last-seen term is too old, then writes a message's touch.
// ----------------------------------------------------------------------------
`default_nettype none

module lept_table #(
  parameter int PEER_SLOTS = lept_pkg::DEF_PEER_SLOTS,
  parameter int TERM_BITS  = lept_pkg::DEF_TERM_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire lept_pkg::tbl_req_t                req,
  input  wire logic [TERM_BITS-1:0]              term,
  output logic                                   done,
  output logic [$clog2(PEER_SLOTS+2)-1:0]        device_total
);

  import lept_pkg::*;

  localparam int DEV_W = $clog2(PEER_SLOTS + 2);
  localparam int IDX_W = $clog2(PEER_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PEER_SLOTS - 1);

  typedef struct packed {
    logic [7:0]           peer;
    logic [TERM_BITS-1:0] seen;
  } slot_t;

  typedef enum logic [2:0] {
    T_IDLE  = 3'b001,
    T_SCAN  = 3'b010,
    T_WRITE = 3'b100
  } tstate_t;

  tstate_t              tstate;
  slot_t                mem [PEER_SLOTS];
  slot_t                rd_slot;
  logic [PEER_SLOTS-1:0] slot_valid;
  logic [IDX_W-1:0]     issue_addr;
  logic                 issuing;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_ok;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic                 free;
  logic [IDX_W-1:0]     free_idx;
  logic                 touch_q;
  logic [7:0]           src_q;
  logic [7:0]           stale_q;

  logic                 rd_valid;
  logic [TERM_BITS-1:0] rd_age;
  logic                 is_hit;
  logic                 is_stale;
  logic                 is_free;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;

  // slot classification, the one compare unit reused for every slot
  always_comb begin
    rd_valid = slot_valid[rd_idx];
    rd_age   = term - rd_slot.seen;
    is_hit   = rd_ok && rd_valid && touch_q && !hit && (rd_slot.peer == src_q);
    is_stale = rd_ok && rd_valid && !is_hit &&
               (rd_age > TERM_BITS'(stale_q));
    is_free  = rd_ok && !rd_valid && !free;
    wr_en    = (tstate == T_WRITE) && (hit || free);
    wr_addr  = hit ? hit_idx : free_idx;
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (issuing) begin
      rd_slot <= mem[issue_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= {src_q, term};
    end
  end

  // scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      tstate       <= T_IDLE;
      issuing      <= 1'b0;
      rd_ok        <= 1'b0;
      done         <= 1'b0;
      slot_valid   <= '0;
      device_total <= DEV_W'(1);
    end else begin
      done <= 1'b0;
      case (tstate)
        T_IDLE: begin
          if (req.start) begin
            tstate     <= T_SCAN;
            issue_addr <= '0;
            issuing    <= 1'b1;
            rd_ok      <= 1'b0;
            hit        <= 1'b0;
            free       <= 1'b0;
            touch_q    <= req.touch;
            src_q      <= req.src_id;
            stale_q    <= req.stale_limit;
          end
        end
        T_SCAN: begin
          rd_ok  <= issuing;
          rd_idx <= issue_addr;
          if (issuing) begin
            if (issue_addr == LAST_IDX) begin
              issuing <= 1'b0;
            end else begin
              issue_addr <= issue_addr + 1'b1;
            end
          end
          if (is_hit) begin
            hit     <= 1'b1;
            hit_idx <= rd_idx;
          end
          if (is_free) begin
            free     <= 1'b1;
            free_idx <= rd_idx;
          end
          if (is_stale) begin
            slot_valid[rd_idx] <= 1'b0;
            device_total       <= device_total - 1'b1;
          end
          if (rd_ok && (rd_idx == LAST_IDX)) begin
            if (touch_q) begin
              tstate <= T_WRITE;
            end else begin
              tstate <= T_IDLE;
              done   <= 1'b1;
            end
          end
        end
        T_WRITE: begin
          // new peer takes the first slot that was free before aging
          if (!hit && free) begin
            slot_valid[free_idx] <= 1'b1;
            device_total         <= device_total + 1'b1;
          end
          tstate <= T_IDLE;
          done   <= 1'b1;
        end
        default: begin
          tstate <= T_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
